// ===== rtl/frmt_pkg.sv =====
// ----------------------------------------------------------------------------
// frmt_pkg
// Shared constants, codes and types of the frame rate meter with timers.
// ----------------------------------------------------------------------------
package frmt_pkg;

   // Number of software timers (1 to 4)
   localparam int NUM_TIMERS = 4;

   // Field widths
   localparam int OP_W     = 2;
   localparam int TICK_W   = 32;
   localparam int TSEL_W   = 2;
   localparam int RATE_W   = 16;
   localparam int MASK_W   = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;

   // Transaction opcodes
   localparam logic [OP_W-1:0] OP_FRAME  = 2'd0;
   localparam logic [OP_W-1:0] OP_ENABLE = 2'd1;
   localparam logic [OP_W-1:0] OP_FREEZE = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_MS      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_READY_RATE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_BASE    = 3'd2;

   // Reset values of the registers
   localparam logic [RATE_W-1:0] WINDOW_MS_RST      = 16'd1000;
   localparam logic [RATE_W-1:0] MIN_READY_RATE_RST = 16'd1;
   localparam logic [TICK_W-1:0] PERIOD_RST         = 32'd1000;

   // Per-timer control for one transaction
   typedef struct packed {
      logic enable_wr;   // enable control addressed to this timer
      logic freeze_wr;   // freeze control addressed to this timer
      logic flag;        // value written by the control
      logic step;        // frame event while ready
   } timer_ctrl_type;

   // One result transaction
   typedef struct packed {
      logic [RATE_W-1:0] frame_rate;
      logic              ready_res;
      logic [TICK_W-1:0] last_delta_ms;
      logic [TICK_W-1:0] ready_tick;
      logic [MASK_W-1:0] expired_mask;
   } rsp_type;

endpackage

// ===== rtl/frmt_timer.sv =====
// ----------------------------------------------------------------------------
// frmt_timer
// One software timer: accumulates frame-to-frame time, saturating, and
// reports expiry when the total reaches its period.
// ----------------------------------------------------------------------------
module frmt_timer (
   input  logic                            clock,
   input  logic                            reset,
   input  frmt_pkg::timer_ctrl_type        ctrl,
   input  logic [frmt_pkg::TICK_W-1:0]     now,
   input  logic [frmt_pkg::TICK_W-1:0]     period,
   output logic                            hit
);
   import frmt_pkg::*;

   logic              enabled_ff, enabled_in;
   logic              frozen_ff, frozen_in;
   logic              prev_valid_ff, prev_valid_in;
   logic [TICK_W-1:0] prev_tick_ff, prev_tick_in;
   logic [TICK_W-1:0] elapsed_ff, elapsed_in;

   logic [TICK_W-1:0] delta;
   logic [TICK_W:0]   sum_wide;
   logic [TICK_W-1:0] sum_sat;

   // Saturating accumulate of the time since the previous frame
   assign delta    = now - prev_tick_ff;
   assign sum_wide = {1'b0, elapsed_ff} + {1'b0, delta};
   assign sum_sat  = sum_wide[TICK_W] ? '1 : sum_wide[TICK_W-1:0];

   // Next state
   always_comb begin
      enabled_in    = enabled_ff;
      frozen_in     = frozen_ff;
      prev_valid_in = prev_valid_ff;
      prev_tick_in  = prev_tick_ff;
      elapsed_in    = elapsed_ff;
      hit           = 1'b0;
      if (ctrl.enable_wr) begin
         enabled_in    = ctrl.flag;
         frozen_in     = 1'b0;
         prev_valid_in = 1'b0;
         elapsed_in    = '0;
      end else if (ctrl.freeze_wr) begin
         frozen_in = ctrl.flag;
         if (ctrl.flag) begin
            prev_valid_in = 1'b0;
         end
      end else if (ctrl.step && enabled_ff && !frozen_ff) begin
         // first step after enable or freeze only records the tick
         if (prev_valid_ff) begin
            if (sum_sat >= period) begin
               elapsed_in = '0;
               hit        = 1'b1;
            end else begin
               elapsed_in = sum_sat;
            end
         end
         prev_valid_in = 1'b1;
         prev_tick_in  = now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff    <= 1'b0;
         frozen_ff     <= 1'b0;
         prev_valid_ff <= 1'b0;
         prev_tick_ff  <= '0;
         elapsed_ff    <= '0;
      end else begin
         enabled_ff    <= enabled_in;
         frozen_ff     <= frozen_in;
         prev_valid_ff <= prev_valid_in;
         prev_tick_ff  <= prev_tick_in;
         elapsed_ff    <= elapsed_in;
      end
   end

endmodule

// ===== rtl/frame_rate_meter_with_timers.sv =====
// ----------------------------------------------------------------------------
// frame_rate_meter_with_timers
// Frame rate meter with a bank of software timers driven by frame events.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one event per transaction: a frame event with its
//   millisecond timestamp, or a timer enable / freeze control. Every
//   accepted event yields exactly one rsp_* transaction holding the latched
//   rate, the sticky ready flag, the last window delta, the last tick seen
//   while ready and the timers that expired on that event.
//   All state is updated in the cycle the event is accepted; the result is
//   registered in the result register (or in the skid register while that
//   one is held) and shown on rsp_*. One event per cycle is sustained while
//   the receiver takes results; the window compare and the per-timer saturating add run in parallel.
//   A two-entry output queue (result register plus skid register) lets
//   req_ready stay high while one result waits; req_ready drops only when
//   both entries are full, so a stalled receiver holds the input back
//   without losing a result.
//   csr_we writes register csr_index with csr_wdata at once; write it only
//   while no transaction is in flight.
//   Synchronous reset restores the register defaults, closes the window,
//   clears all latches, disables all timers and empties the output queue.
// ----------------------------------------------------------------------------
module frame_rate_meter_with_timers (
   input  logic                               clock,
   input  logic                               reset,
   // event channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [frmt_pkg::OP_W-1:0]          req_op,
   input  logic [frmt_pkg::TICK_W-1:0]        req_timestamp_ms,
   input  logic [frmt_pkg::TSEL_W-1:0]        req_timer_select,
   input  logic                               req_control_flag,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [frmt_pkg::RATE_W-1:0]        rsp_frame_rate,
   output logic                               rsp_ready_res,
   output logic [frmt_pkg::TICK_W-1:0]        rsp_last_delta_ms,
   output logic [frmt_pkg::TICK_W-1:0]        rsp_ready_tick,
   output logic [frmt_pkg::MASK_W-1:0]        rsp_expired_mask,
   // register write port
   input  logic                               csr_we,
   input  logic [frmt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [frmt_pkg::CSR_DAT_W-1:0]     csr_wdata
);
   import frmt_pkg::*;

   // Registers
   logic [RATE_W-1:0] window_ms_ff;
   logic [RATE_W-1:0] min_ready_rate_ff;

   // Meter state
   logic              win_valid_ff, win_valid_in;
   logic [TICK_W-1:0] win_start_ff, win_start_in;
   logic [RATE_W-1:0] frame_cnt_ff, frame_cnt_in;
   logic [RATE_W-1:0] rate_ff, rate_in;
   logic              ready_ff, ready_in;
   logic [TICK_W-1:0] delta_ff, delta_in;
   logic [TICK_W-1:0] tick_ff, tick_in;

   // Output queue
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_ff, skid_in;

   logic                  push, pop;
   logic                  is_frame, is_enable, is_freeze;
   logic [TICK_W-1:0]     win_delta;
   logic                  win_latch;
   logic [RATE_W-1:0]     cnt_base;
   logic [NUM_TIMERS-1:0] hit_vec;
   rsp_type               result;

   assign push = req_valid && req_ready;
   assign pop  = out_valid_ff && rsp_ready;

   // Opcode decode; an unused opcode changes no state
   always_comb begin
      is_frame  = 1'b0;
      is_enable = 1'b0;
      is_freeze = 1'b0;
      unique case (req_op)
         OP_FRAME:  is_frame  = push;
         OP_ENABLE: is_enable = push;
         OP_FREEZE: is_freeze = push;
         default:   ;
      endcase
   end

   // Window measurement
   assign win_delta = req_timestamp_ms - win_start_ff;
   assign win_latch = is_frame && win_valid_ff && (win_delta >= {16'b0, window_ms_ff});
   assign cnt_base  = win_latch ? '0 : frame_cnt_ff;

   always_comb begin
      win_valid_in = win_valid_ff || is_frame;
      win_start_in = win_start_ff;
      frame_cnt_in = frame_cnt_ff;
      rate_in      = rate_ff;
      delta_in     = delta_ff;
      ready_in     = ready_ff;
      tick_in      = tick_ff;
      if (is_frame && (!win_valid_ff || win_latch)) begin
         win_start_in = req_timestamp_ms;
      end
      if (win_latch) begin
         rate_in  = frame_cnt_ff;
         delta_in = win_delta;
         if (frame_cnt_ff > min_ready_rate_ff) begin
            ready_in = 1'b1;
         end
      end
      if (is_frame) begin
         // saturating frame count
         frame_cnt_in = (cnt_base == '1) ? cnt_base : cnt_base + 1'b1;
         if (ready_in) begin
            tick_in = req_timestamp_ms;
         end
      end
   end

   // Timer bank, each with its period register
   for (genvar t = 0; t < NUM_TIMERS; t++) begin : g_timer
      logic [TICK_W-1:0] period_ff;
      timer_ctrl_type    ctrl;
      logic              sel_hit;

      assign sel_hit        = (req_timer_select == TSEL_W'(t));
      assign ctrl.enable_wr = is_enable && sel_hit;
      assign ctrl.freeze_wr = is_freeze && sel_hit;
      assign ctrl.flag      = req_control_flag;
      assign ctrl.step      = is_frame && ready_in;

      always_ff @(posedge clock) begin
         if (reset) begin
            period_ff <= PERIOD_RST;
         end else if (csr_we && (csr_index == CSR_PERIOD_BASE + CSR_IDX_W'(t))) begin
            period_ff <= csr_wdata[TICK_W-1:0];
         end
      end

      frmt_timer u_timer (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (ctrl),
         .now    (req_timestamp_ms),
         .period (period_ff),
         .hit    (hit_vec[t])
      );
   end

   // Result of the accepted transaction
   always_comb begin
      result.frame_rate    = rate_in;
      result.ready_res     = ready_in;
      result.last_delta_ms = delta_in;
      result.ready_tick    = tick_in;
      result.expired_mask  = MASK_W'(hit_vec);
   end

   // Output queue: result register with a skid register behind it
   assign req_ready = !skid_valid_ff;
   assign rsp_valid = out_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ms_ff      <= WINDOW_MS_RST;
         min_ready_rate_ff <= MIN_READY_RATE_RST;
      end else if (csr_we) begin
         if (csr_index == CSR_WINDOW_MS) begin
            window_ms_ff <= csr_wdata[RATE_W-1:0];
         end
         if (csr_index == CSR_MIN_READY_RATE) begin
            min_ready_rate_ff <= csr_wdata[RATE_W-1:0];
         end
      end
   end

   // Meter state and queue control
   always_ff @(posedge clock) begin
      if (reset) begin
         win_valid_ff  <= 1'b0;
         win_start_ff  <= '0;
         frame_cnt_ff  <= '0;
         rate_ff       <= '0;
         ready_ff      <= 1'b0;
         delta_ff      <= '0;
         tick_ff       <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         win_valid_ff  <= win_valid_in;
         win_start_ff  <= win_start_in;
         frame_cnt_ff  <= frame_cnt_in;
         rate_ff       <= rate_in;
         ready_ff      <= ready_in;
         delta_ff      <= delta_in;
         tick_ff       <= tick_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Queue payload
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_frame_rate    = out_ff.frame_rate;
   assign rsp_ready_res     = out_ff.ready_res;
   assign rsp_last_delta_ms = out_ff.last_delta_ms;
   assign rsp_ready_tick    = out_ff.ready_tick;
   assign rsp_expired_mask  = out_ff.expired_mask;

endmodule
